// ===== rtl/core/dss_pkg.sv =====
// shared widths, codes and state types of the discrete spectrum sampler
`default_nettype none
package dss_pkg;

    localparam int ENERGY_W   = 24;
    localparam int YIELD_W    = 32;
    localparam int FRAC_W     = 32;
    localparam int WEIGHT_W   = 40;
    localparam int INDEX_W    = 8;
    localparam int STATUS_W   = 3;
    localparam int REQ_W      = 2;
    localparam int PROD_W     = FRAC_W + WEIGHT_W;
    localparam int ENTRY_W    = ENERGY_W + WEIGHT_W;
    localparam int IN_DATA_W  = ENERGY_W + YIELD_W + FRAC_W;
    localparam int OUT_DATA_W = ENERGY_W + INDEX_W;

    localparam logic [REQ_W-1:0] REQ_LOAD   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SAMPLE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_SAMPLED  = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_LOADED   = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_REJECTED = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_EMPTY    = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_CLEARED  = 3'd5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROD,
        S_READ,
        S_CMP,
        S_FETCH,
        S_RESULT
    } dss_state_t;

    typedef enum logic [1:0] {
        P_IDLE,
        P_LOW,
        P_HIGH,
        P_SUM
    } prod_phase_t;

endpackage
`default_nettype wire

// ===== rtl/core/discrete_spectrum_sampler.sv =====
// Discrete line spectrum sampler, top level with request sequencer.
// Load beats append an (energy, yield) line to a table held in one memory with
// its running cumulative weight; a sample beat draws a line by inverse-CDF lookup
// (first entry with cum * 2^FRACTION_BITS >= fraction * total), a clear beat
// empties the table. One request is worked at a time. A sample first forms the
// fraction-times-total product, then does one memory read and one compare per
// search step over the n stored lines, then one read for the chosen energy. The
// next request is taken while a result still waits in the output register.
`default_nettype none
module discrete_spectrum_sampler #(
    parameter int TABLE_ENTRIES = 256,
    parameter int FRACTION_BITS = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // energy_in[23:0], yield_in[55:24], random_fraction[87:56]
    input  logic [dss_pkg::IN_DATA_W-1:0]  s_tdata,
    // req_type[1:0]
    input  logic [dss_pkg::REQ_W-1:0]      s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // energy_out[23:0], entry_index[31:24]
    output logic [dss_pkg::OUT_DATA_W-1:0] m_tdata,
    // status[2:0]
    output logic [dss_pkg::STATUS_W-1:0]   m_tuser
);
    import dss_pkg::*;

    localparam int IDX_W     = $clog2(TABLE_ENTRIES);
    localparam int CNT_W     = $clog2(TABLE_ENTRIES + 1);
    localparam int FRAC_KEEP = (FRACTION_BITS < FRAC_W) ? FRACTION_BITS : FRAC_W;
    localparam int CMP_W     = (WEIGHT_W + FRACTION_BITS > PROD_W) ?
                               (WEIGHT_W + FRACTION_BITS) : PROD_W;
    localparam logic [FRAC_W-1:0] FracMask = {FRAC_W{1'b1}} >> (FRAC_W - FRAC_KEEP);

    dss_state_t          state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [WEIGHT_W-1:0] total_reg, total_next;
    logic [CNT_W-1:0]    lo_reg, lo_next;
    logic [CNT_W-1:0]    hi_reg, hi_next;
    logic [IDX_W-1:0]    addr_reg, addr_next;
    logic [ENERGY_W-1:0] res_energy_reg, res_energy_next;
    logic [IDX_W-1:0]    res_index_reg, res_index_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic                m_valid_reg, m_valid_next;
    logic [ENERGY_W-1:0] m_energy_reg, m_energy_next;
    logic [INDEX_W-1:0]  m_index_reg, m_index_next;
    logic [STATUS_W-1:0] m_status_reg, m_status_next;

    logic                accept;
    logic [REQ_W-1:0]    in_req;
    logic [ENERGY_W-1:0] in_energy;
    logic [YIELD_W-1:0]  in_yield;
    logic [FRAC_W-1:0]   in_frac;

    logic                wr_en;
    logic [ENTRY_W-1:0]  wr_data;
    logic                rd_en;
    logic [IDX_W-1:0]    rd_addr;
    logic [ENTRY_W-1:0]  rd_data;
    logic [ENERGY_W-1:0] rd_energy;
    logic [WEIGHT_W-1:0] rd_cum;

    logic                prod_start;
    logic [PROD_W-1:0]   product;
    logic                prod_done;

    logic [WEIGHT_W:0]   sum_wide;
    logic [WEIGHT_W-1:0] sum_sat;
    logic                table_full;
    logic [CNT_W-1:0]    mid_c;
    logic [CNT_W-1:0]    clamp_c;
    logic                reaches;
    logic [IDX_W+INDEX_W-1:0] res_index_ext;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign in_req    = s_tuser;
    assign in_energy = s_tdata[ENERGY_W-1:0];
    assign in_yield  = s_tdata[ENERGY_W +: YIELD_W];
    assign in_frac   = s_tdata[ENERGY_W+YIELD_W +: FRAC_W] & FracMask;

    assign sum_wide   = {1'b0, total_reg} + (WEIGHT_W+1)'(in_yield);
    assign sum_sat    = sum_wide[WEIGHT_W] ? {WEIGHT_W{1'b1}} : sum_wide[WEIGHT_W-1:0];
    assign table_full = (count_reg >= CNT_W'(TABLE_ENTRIES));
    assign wr_data    = {in_energy, sum_sat};
    assign rd_energy  = rd_data[ENTRY_W-1 -: ENERGY_W];
    assign rd_cum     = rd_data[WEIGHT_W-1:0];

    assign mid_c   = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign clamp_c = (lo_reg >= count_reg) ? (count_reg - CNT_W'(1)) : lo_reg;
    assign reaches = CMP_W'({rd_cum, {FRACTION_BITS{1'b0}}}) >= CMP_W'(product);

    assign res_index_ext = {{INDEX_W{1'b0}}, res_index_reg};

    dss_table_mem #(
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    dss_product u_product (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (prod_start),
        .frac    (in_frac),
        .total   (total_reg),
        .product (product),
        .done    (prod_done)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            total_reg   <= total_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        addr_reg       <= addr_next;
        res_energy_reg <= res_energy_next;
        res_index_reg  <= res_index_next;
        res_status_reg <= res_status_next;
        m_energy_reg   <= m_energy_next;
        m_index_reg    <= m_index_next;
        m_status_reg   <= m_status_next;
    end

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        total_next      = total_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        addr_next       = addr_reg;
        res_energy_next = res_energy_reg;
        res_index_next  = res_index_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg;
        m_energy_next   = m_energy_reg;
        m_index_next    = m_index_reg;
        m_status_next   = m_status_reg;
        wr_en           = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = addr_reg;
        prod_start      = 1'b0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    res_energy_next = '0;
                    res_index_next  = '0;
                    state_next      = S_RESULT;
                    case (in_req)
                        REQ_LOAD: begin
                            if (in_energy == '0 || in_yield == '0) begin
                                res_status_next = STAT_REJECTED;
                            end else if (table_full) begin
                                res_status_next = STAT_FULL;
                            end else begin
                                wr_en           = 1'b1;
                                total_next      = sum_sat;
                                count_next      = count_reg + CNT_W'(1);
                                res_index_next  = count_reg[IDX_W-1:0];
                                res_status_next = STAT_LOADED;
                            end
                        end
                        REQ_SAMPLE: begin
                            if (count_reg == '0) begin
                                res_status_next = STAT_EMPTY;
                            end else begin
                                prod_start = 1'b1;
                                lo_next    = '0;
                                hi_next    = count_reg;
                                state_next = S_PROD;
                            end
                        end
                        REQ_CLEAR: begin
                            count_next      = '0;
                            total_next      = '0;
                            res_status_next = STAT_CLEARED;
                        end
                        default: begin
                            res_status_next = STAT_REJECTED;
                        end
                    endcase
                end
            end
            S_PROD: begin
                if (prod_done) begin
                    state_next = S_READ;
                end
            end
            S_READ: begin
                rd_en = 1'b1;
                if (lo_reg < hi_reg) begin
                    rd_addr    = mid_c[IDX_W-1:0];
                    addr_next  = mid_c[IDX_W-1:0];
                    state_next = S_CMP;
                end else begin
                    // search done, fetch the chosen line (clamped to the last one)
                    rd_addr    = clamp_c[IDX_W-1:0];
                    addr_next  = clamp_c[IDX_W-1:0];
                    state_next = S_FETCH;
                end
            end
            S_CMP: begin
                if (reaches) begin
                    hi_next = CNT_W'(addr_reg);
                end else begin
                    lo_next = CNT_W'(addr_reg) + CNT_W'(1);
                end
                state_next = S_READ;
            end
            S_FETCH: begin
                res_energy_next = rd_energy;
                res_index_next  = addr_reg;
                res_status_next = STAT_SAMPLED;
                state_next      = S_RESULT;
            end
            S_RESULT: begin
                // wait for a free output register
                if (!m_valid_reg || m_tready) begin
                    m_valid_next  = 1'b1;
                    m_energy_next = res_energy_reg;
                    m_index_next  = res_index_ext[INDEX_W-1:0];
                    m_status_next = res_status_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_index_reg, m_energy_reg};
    assign m_tuser  = m_status_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(TABLE_ENTRIES))
        else $error("entry count past table size");

    a_total_matches_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) == (total_reg == '0))
        else $error("weight total disagrees with entry count");

    a_search_window: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_READ || state_reg == S_CMP) |->
        (lo_reg <= hi_reg && hi_reg <= count_reg))
        else $error("search window out of range");

    a_fetch_in_table: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FETCH) |-> (CNT_W'(addr_reg) < count_reg))
        else $error("fetched entry beyond stored lines");

    a_result_from_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_RESULT))
        else $error("output beat raised outside result state");

endmodule
`default_nettype wire

// ===== rtl/core/dss_table_mem.sv =====
// line table memory: energy and cumulative weight per entry, registered read
`default_nettype none
module dss_table_mem #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [ADDR_W-1:0]           wr_addr,
    input  logic [dss_pkg::ENTRY_W-1:0] wr_data,
    input  logic                        rd_en,
    input  logic [ADDR_W-1:0]           rd_addr,
    output logic [dss_pkg::ENTRY_W-1:0] rd_data
);
    import dss_pkg::*;

    logic [ENTRY_W-1:0] table_mem [DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            table_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= table_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// ===== rtl/core/dss_product.sv =====
// fraction times total weight, built from two partial products and their sum
`default_nettype none
module dss_product (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [dss_pkg::FRAC_W-1:0]   frac,
    input  logic [dss_pkg::WEIGHT_W-1:0] total,
    output logic [dss_pkg::PROD_W-1:0]   product,
    output logic                         done
);
    import dss_pkg::*;

    localparam int LO_W = FRAC_W + 32;
    localparam int HI_W = FRAC_W + WEIGHT_W - 32;

    prod_phase_t         phase_reg, phase_next;
    logic [FRAC_W-1:0]   frac_reg, frac_next;
    logic [WEIGHT_W-1:0] total_reg, total_next;
    logic [LO_W-1:0]     lo_part_reg, lo_part_next;
    logic [HI_W-1:0]     hi_part_reg, hi_part_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic                done_reg, done_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= P_IDLE;
            done_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        frac_reg    <= frac_next;
        total_reg   <= total_next;
        lo_part_reg <= lo_part_next;
        hi_part_reg <= hi_part_next;
        prod_reg    <= prod_next;
    end

    always_comb begin
        phase_next   = phase_reg;
        frac_next    = frac_reg;
        total_next   = total_reg;
        lo_part_next = lo_part_reg;
        hi_part_next = hi_part_reg;
        prod_next    = prod_reg;
        done_next    = 1'b0;
        case (phase_reg)
            P_IDLE: begin
                if (start) begin
                    frac_next  = frac;
                    total_next = total;
                    phase_next = P_LOW;
                end
            end
            P_LOW: begin
                lo_part_next = LO_W'(frac_reg) * LO_W'(total_reg[31:0]);
                phase_next   = P_HIGH;
            end
            P_HIGH: begin
                hi_part_next = HI_W'(frac_reg) * HI_W'(total_reg[WEIGHT_W-1:32]);
                phase_next   = P_SUM;
            end
            P_SUM: begin
                prod_next  = PROD_W'(lo_part_reg) + {hi_part_reg, 32'd0};
                done_next  = 1'b1;
                phase_next = P_IDLE;
            end
            default: begin
                phase_next = P_IDLE;
            end
        endcase
    end

    assign product = prod_reg;
    assign done    = done_reg;

endmodule
`default_nettype wire

// ===== tb/discrete_spectrum_sampler_test.sv =====
// self-checking testbench for the discrete spectrum sampler: line loads, inverse-cdf draws, clears
`timescale 1ns / 100ps
module discrete_spectrum_sampler_test;
    import dss_pkg::*;

    localparam int                LINES       = 256;
    localparam int                QUIET_LIMIT = 4000;
    localparam int                DRAIN_WAIT  = 64;
    localparam int                REPORT_MAX  = 20;
    localparam int                ITEM_TARGET = 1100;
    localparam logic [REQ_W-1:0]  REQ_UNUSED  = 2'd3;

    typedef struct packed {
        logic [REQ_W-1:0]    kind;
        logic [ENERGY_W-1:0] energy;
        logic [YIELD_W-1:0]  yld;
        logic [FRAC_W-1:0]   frac;
    } line_req_t;

    typedef struct packed {
        logic [ENERGY_W-1:0] energy;
        logic [INDEX_W-1:0]  index;
        logic [STATUS_W-1:0] status;
    } line_res_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic [REQ_W-1:0]      s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]   m_tuser;

    discrete_spectrum_sampler u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // energy_in, yield_in, random_fraction
        .s_tuser  (s_tuser),   // req_type
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // energy_out, entry_index
        .m_tuser  (m_tuser)    // status
    );

    always #1 aclk = ~aclk;

    line_req_t pending_reqs[$];
    line_res_t expected_results[$];
    line_req_t on_bus;
    int        reqs_total;
    int        beats_in    = 0;
    int        results_out = 0;
    int        errors      = 0;
    int        idle_phase;
    int        n_load = 0, n_sample = 0, n_clear = 0, n_unused = 0;
    int        n_full = 0, n_empty = 0, n_reject = 0;

    // predictor state
    logic [ENERGY_W-1:0] line_energy_q[LINES];
    logic [WEIGHT_W-1:0] line_cum_q[LINES];
    int unsigned         line_count = 0;
    logic [WEIGHT_W-1:0] weight_sum = '0;

    // stimulus-side bookkeeping of the same table, used to aim fractions at cdf steps
    logic [WEIGHT_W-1:0] gen_cum[LINES];
    int                  gen_count = 0;
    logic [WEIGHT_W-1:0] gen_total = '0;

    // rotate through idle phases every 50 accepted input beats
    assign idle_phase = (beats_in / 50) % 4;

    task automatic report_mismatch(input string what);
        if (errors < REPORT_MAX)
            $display("[%0t] mismatch: %s", $time, what);
        errors++;
    endtask

    function automatic line_res_t predict_line_draw(input line_req_t r);
        line_res_t           res;
        logic [WEIGHT_W:0]   sum;
        logic [71:0]         lhs, rhs;
        int unsigned         lo, hi, mid;
        res = '{energy: '0, index: '0, status: STAT_REJECTED};
        case (r.kind)
            REQ_LOAD: begin
                n_load++;
                if (r.energy == '0 || r.yld == '0) begin
                    res.status = STAT_REJECTED;
                    n_reject++;
                end else if (line_count >= LINES) begin
                    res.status = STAT_FULL;
                    n_full++;
                end else begin
                    sum = {1'b0, weight_sum} + {{(WEIGHT_W + 1 - YIELD_W){1'b0}}, r.yld};
                    if (sum[WEIGHT_W])
                        sum = {1'b0, {WEIGHT_W{1'b1}}};
                    line_energy_q[line_count] = r.energy;
                    line_cum_q[line_count]    = sum[WEIGHT_W-1:0];
                    weight_sum                = sum[WEIGHT_W-1:0];
                    res.index                 = line_count[INDEX_W-1:0];
                    res.status                = STAT_LOADED;
                    line_count++;
                end
            end
            REQ_SAMPLE: begin
                n_sample++;
                if (line_count == 0) begin
                    res.status = STAT_EMPTY;
                    n_empty++;
                end else begin
                    rhs = {40'b0, r.frac} * {32'b0, weight_sum};
                    lo  = 0;
                    hi  = line_count;
                    while (lo < hi) begin
                        mid = lo + (hi - lo) / 2;
                        lhs = {line_cum_q[mid], 32'b0};
                        if (lhs >= rhs)
                            hi = mid;
                        else
                            lo = mid + 1;
                    end
                    if (lo >= line_count)
                        lo = line_count - 1;
                    res.energy = line_energy_q[lo];
                    res.index  = lo[INDEX_W-1:0];
                    res.status = STAT_SAMPLED;
                end
            end
            REQ_CLEAR: begin
                n_clear++;
                line_count = 0;
                weight_sum = '0;
                res.status = STAT_CLEARED;
            end
            default: n_unused++;
        endcase
        return res;
    endfunction

    // sender: holds a beat until taken, then maybe idles before the next one
    always @(posedge aclk) begin : sender
        int send_idle_pct;
        send_idle_pct = (idle_phase == 1) ? 76 : (idle_phase == 3) ? 14 : 0;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_results.insert(expected_results.size(), predict_line_draw(on_bus));
                beats_in++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    on_bus = pending_reqs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {on_bus.frac, on_bus.yld, on_bus.energy};
                    s_tuser  <= on_bus.kind;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: checks each result beat against the oldest prediction
    always @(posedge aclk) begin : receiver
        line_res_t got, want;
        int        stall_pct;
        stall_pct = (idle_phase == 2) ? 76 : (idle_phase == 3) ? 14 : 0;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = '{energy: m_tdata[ENERGY_W-1:0],
                        index: m_tdata[ENERGY_W +: INDEX_W],
                        status: m_tuser};
                results_out++;
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result e=%0h idx=%0d st=%0d",
                                              got.energy, got.index, got.status));
                end else begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status)
                        report_mismatch($sformatf("result %0d status %0d, want %0d",
                                                  results_out, got.status, want.status));
                    if (got.index !== want.index)
                        report_mismatch($sformatf("result %0d index %0d, want %0d",
                                                  results_out, got.index, want.index));
                    if (got.energy !== want.energy)
                        report_mismatch($sformatf("result %0d energy %0h, want %0h",
                                                  results_out, got.energy, want.energy));
                end
            end
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge aclk) begin : watchdog
        int quiet;
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("watchdog: no beat for %0d cycles, %0d of %0d requests taken",
                         quiet, beats_in, reqs_total);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    task automatic push_req(input logic [REQ_W-1:0] kind, input logic [ENERGY_W-1:0] e,
                            input logic [YIELD_W-1:0] y, input logic [FRAC_W-1:0] f);
        line_req_t item;
        item = '{kind: kind, energy: e, yld: y, frac: f};
        pending_reqs.insert(pending_reqs.size(), item);
        if (kind == REQ_CLEAR) begin
            gen_count = 0;
            gen_total = '0;
        end else if (kind == REQ_LOAD && e != '0 && y != '0 && gen_count < LINES) begin
            gen_total          = gen_total + y;
            gen_cum[gen_count] = gen_total;
            gen_count++;
        end
    endtask

    function automatic logic [ENERGY_W-1:0] rand_energy();
        if ($urandom_range(0, 1) == 0)
            return ENERGY_W'($urandom);
        return ENERGY_W'($urandom_range(1, 5000));
    endfunction

    function automatic logic [YIELD_W-1:0] rand_yield();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1:       return $urandom_range(1, 16);
            2:       return 32'h1 << $urandom_range(0, 31);
            default: return $urandom >> $urandom_range(0, 31);
        endcase
    endfunction

    // fraction that lands on, just below or just above a cdf step
    function automatic logic [FRAC_W-1:0] step_fraction();
        logic [71:0] v;
        int          j;
        if (gen_count == 0 || gen_total == '0)
            return $urandom;
        j = $urandom_range(0, gen_count - 1);
        v = {gen_cum[j], 32'b0} / {32'b0, gen_total};
        case ($urandom_range(0, 2))
            0: v = (v == 0) ? v : v - 1;
            1: v = v + 1;
            default: ;
        endcase
        if (v > 72'hFFFF_FFFF)
            v = 72'hFFFF_FFFF;
        return v[FRAC_W-1:0];
    endfunction

    function automatic logic [FRAC_W-1:0] rand_fraction();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 5)
            return $urandom;
        if (pick < 8)
            return step_fraction();
        return (pick == 8) ? '0 : '1;
    endfunction

    initial begin : stimulus
        int n_lines, n_draws;
        bit fill_done;
        fill_done = 0;

        // directed: empty draw, rejects, unused code, extreme lines and fractions
        push_req(REQ_SAMPLE, 24'h123456, 32'h1, 32'h8000_0000);
        push_req(REQ_LOAD, '0, 32'h10, $urandom);
        push_req(REQ_LOAD, 24'h00ABCD, '0, $urandom);
        push_req(REQ_UNUSED, '1, '1, '1);
        push_req(REQ_LOAD, '1, '1, '0);
        push_req(REQ_LOAD, 24'h1, 32'h1, '1);
        push_req(REQ_LOAD, 24'h5A5A5A, '1, $urandom);
        push_req(REQ_LOAD, 24'hA5A5A5, 32'h8000_0000, $urandom);
        push_req(REQ_SAMPLE, '0, '0, '0);
        push_req(REQ_SAMPLE, '1, '1, '1);
        push_req(REQ_SAMPLE, '0, '0, 32'h8000_0000);
        repeat (4) push_req(REQ_SAMPLE, ENERGY_W'($urandom), $urandom, step_fraction());
        push_req(REQ_CLEAR, '1, '1, '1);
        push_req(REQ_SAMPLE, '0, '0, '1);
        push_req(REQ_CLEAR, '0, '0, '0);
        push_req(REQ_LOAD, 24'h00FFFF, 32'h7, '0);
        push_req(REQ_SAMPLE, '0, '0, '1);
        push_req(REQ_SAMPLE, '0, '0, '0);

        // random: clear, a run of loads, then draws; some noise in between
        while (pending_reqs.size() < ITEM_TARGET) begin
            if ($urandom_range(0, 3) != 0)
                push_req(REQ_CLEAR, ENERGY_W'($urandom), $urandom, $urandom);
            if ($urandom_range(0, 5) == 0)
                push_req(REQ_SAMPLE, ENERGY_W'($urandom), $urandom, $urandom);
            if (!fill_done)
                n_lines = LINES + 3;
            else if ($urandom_range(0, 7) == 0)
                n_lines = $urandom_range(13, 60);
            else
                n_lines = $urandom_range(1, 12);
            fill_done = 1;
            while (n_lines > 0) begin
                case ($urandom_range(0, 19))
                    0:       push_req(REQ_LOAD, '0, rand_yield(), $urandom);
                    1:       push_req(REQ_LOAD, rand_energy(), '0, $urandom);
                    2:       push_req(REQ_UNUSED, ENERGY_W'($urandom), $urandom, $urandom);
                    default: begin
                        push_req(REQ_LOAD, rand_energy(), rand_yield(), $urandom);
                        n_lines--;
                    end
                endcase
            end
            n_draws = $urandom_range(4, 20);
            repeat (n_draws)
                push_req(REQ_SAMPLE, ENERGY_W'($urandom), $urandom, rand_fraction());
        end
        reqs_total = pending_reqs.size();

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        while (beats_in < reqs_total || expected_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("covered %0d loads, %0d draws, %0d clears, %0d unused codes; %0d results",
                 n_load, n_sample, n_clear, n_unused, results_out);
        $display("  incl. %0d full-table loads, %0d rejected loads, %0d empty-table draws",
                 n_full, n_reject, n_empty);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatches", errors);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
